### hw/rtl/dof_pkg.sv
// Shared types, constants and helpers for the DHCP option finder.
package dof_pkg;

    localparam int OPTION_AREA_BYTES = 308;
    localparam int FILE_AREA_BYTES   = 128;
    localparam int NAME_AREA_BYTES   = 64;

    localparam int OFFSET_W = 10;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    localparam logic [7:0] CODE_PAD      = 8'h00;
    localparam logic [7:0] CODE_OVERLOAD = 8'h34;
    localparam logic [7:0] CODE_END      = 8'hFF;

    localparam logic [7:0] TARGET_RESET = 8'd12;

    localparam logic [1:0] REGION_OPTIONS = 2'd0;
    localparam logic [1:0] REGION_FILE    = 2'd1;
    localparam logic [1:0] REGION_SNAME   = 2'd2;
    localparam logic [1:0] REGION_NONE    = 2'd3;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BOGUS     = 2'd2
    } status_t;

    typedef struct packed {
        logic       packet_last;
        logic       region_last;
        logic [1:0] region;
        logic [7:0] data_byte;
    } beat_t;

    typedef struct packed {
        logic [7:0] data_length;
        logic [8:0] data_offset;
        logic [1:0] found_region;
        status_t    status;
    } result_t;

    function automatic logic [OFFSET_W-1:0] region_size(input logic [1:0] r);
        logic [OFFSET_W-1:0] s;
        case (r)
            REGION_OPTIONS: s = OFFSET_W'(OPTION_AREA_BYTES);
            REGION_FILE:    s = OFFSET_W'(FILE_AREA_BYTES);
            default:        s = OFFSET_W'(NAME_AREA_BYTES);
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/dof_in_stage.sv
// Input register for incoming byte beats.
module dof_in_stage
    import dof_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_beat,
    input  logic  take,
    output logic  valid,
    output beat_t beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

### hw/rtl/dof_parser.sv
// Option record walker: parse state, target register and per-beat decision.
module dof_parser
    import dof_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       beat_valid,
    input  beat_t      beat,
    input  logic       out_free,
    output logic       take,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_CODE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_OVERVAL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PLAIN    = 2'd0,
        KIND_TARGET   = 2'd1,
        KIND_OVERLOAD = 2'd2
    } kind_t;

    logic [7:0]          target_reg;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [OFFSET_W-1:0] next_pos_reg, next_pos_next;
    phase_t              phase_reg, phase_next;
    kind_t               kind_reg, kind_next;
    logic [1:0]          flags_reg, flags_next;
    logic [1:0]          active_reg, active_next;
    logic                concluded_reg, concluded_next;

    logic [OFFSET_W-1:0] size;
    logic [OFFSET_W:0]   off_plus1;
    logic [OFFSET_W:0]   rec_end;
    logic [7:0]          b;

    always_comb
    begin
        b         = beat.data_byte;
        size      = region_size(active_reg);
        off_plus1 = {1'b0, offset_reg} + (OFFSET_W+1)'(1);
        rec_end   = off_plus1 + (OFFSET_W+1)'(b);

        offset_next    = offset_reg;
        next_pos_next  = next_pos_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        flags_next     = flags_reg;
        active_next    = active_reg;
        concluded_next = concluded_reg;

        res_valid        = 1'b0;
        res.status       = ST_BOGUS;
        res.found_region = 2'd0;
        res.data_offset  = 9'd0;
        res.data_length  = 8'd0;

        if (!concluded_reg && beat.region == active_reg && beat.region != REGION_NONE
            && offset_reg < size)
        begin
            case (phase_reg)
                PH_CODE:
                begin
                    if (offset_reg == next_pos_reg)
                    begin
                        if (b == target_reg || b == CODE_OVERLOAD
                            || (b != CODE_PAD && b != CODE_END))
                        begin
                            kind_next = (b == target_reg)    ? KIND_TARGET :
                                        (b == CODE_OVERLOAD) ? KIND_OVERLOAD : KIND_PLAIN;
                            if (off_plus1 >= {1'b0, size})
                            begin
                                res_valid      = 1'b1;
                                concluded_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_LENGTH;
                            end
                        end
                        else if (b == CODE_PAD)
                        begin
                            next_pos_next = off_plus1[OFFSET_W-1:0];
                            if (off_plus1 >= {1'b0, size})
                            begin
                                res_valid      = 1'b1;
                                concluded_next = 1'b1;
                            end
                        end
                        else if (active_reg == REGION_OPTIONS && flags_reg[0])
                        begin
                            active_next   = REGION_FILE;
                            next_pos_next = '0;
                        end
                        else if (active_reg == REGION_FILE && flags_reg[1])
                        begin
                            active_next   = REGION_SNAME;
                            next_pos_next = '0;
                        end
                        else
                        begin
                            res_valid      = 1'b1;
                            res.status     = ST_NOT_FOUND;
                            concluded_next = 1'b1;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    phase_next = PH_CODE;
                    if (kind_reg == KIND_TARGET)
                    begin
                        res_valid      = 1'b1;
                        concluded_next = 1'b1;
                        if (rec_end <= {1'b0, size})
                        begin
                            res.status       = ST_FOUND;
                            res.found_region = active_reg;
                            res.data_offset  = off_plus1[8:0];
                            res.data_length  = b;
                        end
                    end
                    else if (rec_end >= {1'b0, size})
                    begin
                        res_valid      = 1'b1;
                        concluded_next = 1'b1;
                    end
                    else
                    begin
                        next_pos_next = rec_end[OFFSET_W-1:0];
                        if (kind_reg == KIND_OVERLOAD)
                        begin
                            if (b == 8'd0)
                            begin
                                flags_next = 2'd0;
                            end
                            else
                            begin
                                phase_next = PH_OVERVAL;
                            end
                        end
                    end
                    kind_next = KIND_PLAIN;
                end
                default:
                begin
                    flags_next = b[1:0];
                    phase_next = PH_CODE;
                end
            endcase
            // searched region ran out before END
            if (!concluded_next && beat.region_last && beat.region == active_next)
            begin
                res_valid      = 1'b1;
                res.status     = ST_BOGUS;
                concluded_next = 1'b1;
            end
        end
        else if (!concluded_reg && beat.region_last && beat.region == active_reg
                 && beat.region != REGION_NONE)
        begin
            res_valid      = 1'b1;
            concluded_next = 1'b1;
        end

        if (beat.region_last)
        begin
            offset_next = '0;
        end
        else if (offset_reg < OFFSET_MAX)
        begin
            offset_next = offset_reg + OFFSET_W'(1);
        end

        if (beat.packet_last)
        begin
            if (!concluded_next)
            begin
                res_valid  = 1'b1;
                res.status = ST_BOGUS;
            end
            offset_next    = '0;
            next_pos_next  = '0;
            phase_next     = PH_CODE;
            kind_next      = KIND_PLAIN;
            flags_next     = 2'd0;
            active_next    = REGION_OPTIONS;
            concluded_next = 1'b0;
        end

        res_valid = res_valid && beat_valid;
        take      = beat_valid && (!res_valid || out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            offset_reg    <= '0;
            next_pos_reg  <= '0;
            phase_reg     <= PH_CODE;
            kind_reg      <= KIND_PLAIN;
            flags_reg     <= 2'd0;
            active_reg    <= REGION_OPTIONS;
            concluded_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (take)
            begin
                offset_reg    <= offset_next;
                next_pos_reg  <= next_pos_next;
                phase_reg     <= phase_next;
                kind_reg      <= kind_next;
                flags_reg     <= flags_next;
                active_reg    <= active_next;
                concluded_reg <= concluded_next;
            end
        end
    end

    a_one_result_per_packet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !concluded_reg)
        else $error("second result in one packet");

    a_packet_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_valid && beat.packet_last && !concluded_reg) |-> res_valid)
        else $error("packet ended without a result");

    a_packet_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && beat.packet_last) |=> (!concluded_reg && active_reg == REGION_OPTIONS
                                         && offset_reg == '0))
        else $error("parse state not cleared after packet end");

    a_found_on_length: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_FOUND) |-> (phase_reg == PH_LENGTH
                                                     && kind_reg == KIND_TARGET))
        else $error("found reported outside a target length byte");

endmodule

### hw/rtl/dof_out_stage.sv
// Result register towards the master side.
module dof_out_stage
    import dof_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hw/rtl/dhcp_option_finder.sv
// DHCP option finder top level: stream ports, input register, parser, result register.
// Streams one DHCP packet a byte per beat (option area, then file, then server name)
// and returns one result beat per packet for the configured option code: found with
// region, data offset and length, not found, or bogus. One byte beat is taken every
// clock cycle unless a result beat waits for the result register; the deciding beat
// passes the input register and its result is held in the result register. Input
// back-pressure follows the result register only on beats that produce a result. The
// target code may be written only while no packet is in flight; it resets to 12.
module dhcp_option_finder
    import dof_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // target_code
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [1:0] region, [2] region_last
    input  logic        s_axis_tlast,   // packet_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] found_region, [10:2] data_offset,
                                        // [18:11] data_length, [23:19] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    beat_t   in_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    take;
    logic    res_valid;
    result_t res;
    logic    out_free;
    result_t out_res;

    assign in_beat.data_byte   = s_axis_tdata;
    assign in_beat.region      = s_axis_tuser[1:0];
    assign in_beat.region_last = s_axis_tuser[2];
    assign in_beat.packet_last = s_axis_tlast;

    dof_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_beat  (in_beat),
        .take     (take),
        .valid    (beat_valid),
        .beat     (beat)
    );

    dof_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat_valid  (beat_valid),
        .beat        (beat),
        .out_free    (out_free),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    dof_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {5'd0, out_res.data_length, out_res.data_offset,
                           out_res.found_region};
    assign m_axis_tuser = out_res.status;

endmodule

### dv/tb_dhcp_option_finder.sv
// Testbench for dhcp_option_finder: streamed packets, byte-level search predictor, result checks.
module tb_dhcp_option_finder;
    import dof_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_WAIT = 8;

    typedef enum logic [1:0] {
        SEEK_CODE,
        SEEK_LENGTH,
        SEEK_OVERLOAD
    } seek_t;

    typedef enum logic [1:0] {
        REC_PLAIN,
        REC_TARGET,
        REC_OVERLOAD
    } rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [2:0]  s_axis_tuser = 3'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    dhcp_option_finder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    beat_t       stream_q[$];
    beat_t       next_beat;
    result_t     verdict_q[$];
    result_t     head_verdict;
    logic [7:0]  area_q[$];

    // search state mirrored from the block
    logic [7:0]  find_code = TARGET_RESET;
    logic [9:0]  area_pos;
    logic [9:0]  rec_start;
    seek_t       seek;
    rec_t        rec;
    logic [1:0]  ovl_flags;
    logic [1:0]  walk_region;
    logic        settled;

    int          errors = 0;
    int          cycles = 0;
    int          beats_made = 0;
    int          src_idle_pct = 8;
    int          sink_idle_pct = 8;
    logic        hold_go = 1'b0;
    logic        sink_hold = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (errors < 50)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic clear_walk();
        area_pos = '0;
        rec_start = '0;
        seek = SEEK_CODE;
        rec = REC_PLAIN;
        ovl_flags = 2'd0;
        walk_region = REGION_OPTIONS;
        settled = 1'b0;
    endtask

    task automatic settle(input status_t st, input logic [1:0] rgn, input logic [8:0] off,
                          input logic [7:0] len);
        result_t v;
        v.status = st;
        v.found_region = rgn;
        v.data_offset = off;
        v.data_length = len;
        verdict_q.push_back(v);
        settled = 1'b1;
    endtask

    task automatic walk_option_byte(input logic [7:0] b, input logic [1:0] rgn, input logic rl,
                                    input logic pl);
        int lim;
        int stop;
        lim = (walk_region == REGION_OPTIONS) ? OPTION_AREA_BYTES :
              (walk_region == REGION_FILE) ? FILE_AREA_BYTES : NAME_AREA_BYTES;
        if (!settled && rgn == walk_region && rgn != REGION_NONE && int'(area_pos) < lim)
        begin
            case (seek)
                SEEK_CODE:
                begin
                    if (area_pos == rec_start)
                    begin
                        if (b == find_code || (b != CODE_PAD && b != CODE_END))
                        begin
                            rec = (b == find_code) ? REC_TARGET :
                                  (b == CODE_OVERLOAD) ? REC_OVERLOAD : REC_PLAIN;
                            if (int'(area_pos) + 1 >= lim)
                                settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);
                            else
                                seek = SEEK_LENGTH;
                        end
                        else if (b == CODE_PAD)
                        begin
                            rec_start = 10'(int'(area_pos) + 1);
                            if (int'(rec_start) >= lim)
                                settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);
                        end
                        else if (walk_region == REGION_OPTIONS && ovl_flags[0])
                        begin
                            walk_region = REGION_FILE;
                            rec_start = '0;
                        end
                        else if (walk_region == REGION_FILE && ovl_flags[1])
                        begin
                            walk_region = REGION_SNAME;
                            rec_start = '0;
                        end
                        else
                            settle(ST_NOT_FOUND, 2'd0, 9'd0, 8'd0);
                    end
                end
                SEEK_LENGTH:
                begin
                    stop = int'(area_pos) + 1 + int'(b);
                    seek = SEEK_CODE;
                    if (rec == REC_TARGET)
                    begin
                        if (stop > lim)
                            settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);
                        else
                            settle(ST_FOUND, walk_region, 9'(int'(area_pos) + 1), b);
                    end
                    else if (stop >= lim)
                        settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);
                    else
                    begin
                        rec_start = 10'(stop);
                        if (rec == REC_OVERLOAD)
                        begin
                            if (b == 8'd0)
                                ovl_flags = 2'd0;
                            else
                                seek = SEEK_OVERLOAD;
                        end
                    end
                    rec = REC_PLAIN;
                end
                default:
                begin
                    ovl_flags = b[1:0];
                    seek = SEEK_CODE;
                end
            endcase
            // searched region ran out before END
            if (!settled && rl && rgn == walk_region)
                settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);
        end
        else if (!settled && rl && rgn == walk_region && rgn != REGION_NONE)
            settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);

        if (rl)
            area_pos = '0;
        else if (area_pos != OFFSET_MAX)
            area_pos = area_pos + 10'd1;

        if (pl)
        begin
            if (!settled)
                settle(ST_BOGUS, 2'd0, 9'd0, 8'd0);
            clear_walk();
        end
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'd0;
            s_axis_tuser <= 3'd0;
            s_axis_tlast <= 1'b0;
            clear_walk();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                walk_option_byte(s_axis_tdata, s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stream_q.size() != 0 && int'($urandom_range(99)) >= src_idle_pct)
                begin
                    next_beat = stream_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_beat.data_byte;
                    s_axis_tuser <= {next_beat.region_last, next_beat.region};
                    s_axis_tlast <= next_beat.packet_last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !sink_hold && int'($urandom_range(99)) >= sink_idle_pct;
    end

    // long sink hold-off so the block backs up into its input
    initial
    begin
        while (!hold_go)
            @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
                flag_mismatch("result beat with none pending", int'(m_axis_tuser), -1);
            else
            begin
                head_verdict = verdict_q.pop_front();
                if (m_axis_tuser != head_verdict.status)
                    flag_mismatch("status", int'(m_axis_tuser), int'(head_verdict.status));
                if (m_axis_tdata[1:0] != head_verdict.found_region)
                    flag_mismatch("found_region", int'(m_axis_tdata[1:0]),
                                  int'(head_verdict.found_region));
                if (m_axis_tdata[10:2] != head_verdict.data_offset)
                    flag_mismatch("data_offset", int'(m_axis_tdata[10:2]),
                                  int'(head_verdict.data_offset));
                if (m_axis_tdata[18:11] != head_verdict.data_length)
                    flag_mismatch("data_length", int'(m_axis_tdata[18:11]),
                                  int'(head_verdict.data_length));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[dhcp_option_finder] ERROR");
            $finish;
        end
    end

    task automatic add_beat(input logic [7:0] b, input logic [1:0] rgn, input logic rl,
                            input logic pl);
        beat_t bt;
        bt.data_byte = b;
        bt.region = rgn;
        bt.region_last = rl;
        bt.packet_last = pl;
        stream_q.push_back(bt);
        beats_made++;
    endtask

    function automatic logic [7:0] pick_plain_code();
        logic [7:0] c;
        c = 8'($urandom_range(1, 254));
        while (c == CODE_OVERLOAD || c == find_code)
            c = 8'($urandom_range(1, 254));
        return c;
    endfunction

    task automatic put_record(input logic [7:0] code, input int len);
        area_q.push_back(code);
        area_q.push_back(8'(len));
        repeat (len) area_q.push_back(8'($urandom_range(255)));
    endtask

    // one region's bytes: records, optional overload and target, END, filler
    task automatic build_area(input int limit, input bit full, input bit want_ovl,
                              input logic [1:0] ovl_val, input bit want_target);
        int nrec;
        int tpos;
        int len;
        int delta;
        int fill_to;
        area_q.delete();
        if (want_ovl)
        begin
            len = ($urandom_range(9) == 0) ? 0 : (($urandom_range(3) == 0) ? 2 : 1);
            area_q.push_back(CODE_OVERLOAD);
            area_q.push_back(8'(len));
            if (len > 0)
                area_q.push_back({6'($urandom_range(63)), ovl_val});
            if (len > 1)
                area_q.push_back(8'($urandom_range(255)));
        end
        nrec = int'($urandom_range(4));
        tpos = want_target ? int'($urandom_range(nrec)) : -1;
        for (int i = 0; i <= nrec; i++)
        begin
            if (i == tpos)
                put_record(find_code, int'($urandom_range(8)));
            if (i < nrec)
            begin
                if ($urandom_range(9) < 2)
                    area_q.push_back(CODE_PAD);
                else
                    put_record(pick_plain_code(), int'($urandom_range(5)));
            end
        end
        if (full)
        begin
            while (limit - area_q.size() - 2 > 255)
                put_record(pick_plain_code(), 200);
            delta = int'($urandom_range(3)) - 2;
            len = limit - area_q.size() - 2 + delta;
            if (len > 255)
                len = 255;
            if (len >= 0)
                put_record(($urandom_range(2) == 0) ? find_code : pick_plain_code(), len);
            if (area_q.size() < limit && $urandom_range(1) == 0)
                area_q.push_back(CODE_END);
            fill_to = limit + int'($urandom_range(2));
            while (area_q.size() < fill_to)
                area_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(99) < 92)
                area_q.push_back(CODE_END);
            repeat ($urandom_range(3)) area_q.push_back(8'($urandom_range(255)));
        end
        if (area_q.size() == 0)
            area_q.push_back(CODE_END);
    endtask

    task automatic emit_area(input logic [1:0] rgn, input bit pl);
        int last;
        last = area_q.size() - 1;
        for (int i = 0; i <= last; i++)
            add_beat(area_q[i], rgn, i == last, pl && i == last);
        area_q.delete();
    endtask

    task automatic make_packet();
        logic [1:0] ovl;
        int where;
        bit with_file;
        bit with_name;
        ovl = 2'($urandom_range(3));
        where = int'($urandom_range(4));
        with_file = $urandom_range(9) < 8;
        with_name = with_file && $urandom_range(9) < 7;
        build_area(OPTION_AREA_BYTES, $urandom_range(99) < 2, $urandom_range(9) < 5, ovl,
                   where == 0);
        emit_area(REGION_OPTIONS, !with_file);
        if (with_file)
        begin
            build_area(FILE_AREA_BYTES, $urandom_range(99) < 5, 1'b0, 2'd0, where == 1);
            emit_area(REGION_FILE, !with_name);
        end
        if (with_name)
        begin
            build_area(NAME_AREA_BYTES, $urandom_range(99) < 10, 1'b0, 2'd0, where == 2);
            emit_area(REGION_SNAME, 1'b1);
        end
    endtask

    // junk beats and truncated packets
    task automatic make_noise();
        int n;
        n = int'($urandom_range(1, 30));
        for (int i = 0; i < n; i++)
            add_beat(8'($urandom_range(255)), 2'($urandom_range(3)), $urandom_range(7) == 0,
                     i == n - 1 || $urandom_range(19) == 0);
    endtask

    task automatic drain();
        while (stream_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic set_target(input logic [7:0] code);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        find_code = code;
    endtask

    initial
    begin
        logic [7:0] code;
        int goal;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset target 12
        add_beat(8'd12, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd2, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'h00, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'hFF, REGION_OPTIONS, 1'b1, 1'b1);
        add_beat(CODE_PAD, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd3, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd1, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'h55, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(CODE_END, REGION_OPTIONS, 1'b1, 1'b1);
        add_beat(CODE_OVERLOAD, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd1, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd1, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(CODE_END, REGION_OPTIONS, 1'b1, 1'b0);
        add_beat(8'd12, REGION_FILE, 1'b0, 1'b0);
        add_beat(8'd0, REGION_FILE, 1'b1, 1'b1);
        add_beat(8'd5, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd0, REGION_OPTIONS, 1'b1, 1'b1);
        add_beat(8'd7, REGION_OPTIONS, 1'b0, 1'b1);
        add_beat(CODE_OVERLOAD, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(8'd0, REGION_OPTIONS, 1'b0, 1'b0);
        add_beat(CODE_END, REGION_OPTIONS, 1'b1, 1'b1);
        add_beat(8'hFF, REGION_NONE, 1'b1, 1'b1);

        for (int p = 0; p < 7; p++)
        begin
            drain();
            case (p)
                0:       code = 8'h00;
                1:       code = 8'hFF;
                2:       code = CODE_OVERLOAD;
                3:       code = 8'($urandom_range(1, 254));
                4:       code = TARGET_RESET;
                5:       code = 8'd1;
                default: code = 8'hFE;
            endcase
            set_target(code);
            src_idle_pct = (p == 3) ? 0 : 8;
            sink_idle_pct = (p == 3) ? 0 : 8;
            if (p == 1)
                hold_go = 1'b1;
            goal = beats_made + 225;
            while (beats_made < goal)
            begin
                if ($urandom_range(99) < 15)
                    make_noise();
                else
                    make_packet();
            end
        end

        drain();
        if (errors == 0)
            $display("[dhcp_option_finder] OK");
        else
            $display("[dhcp_option_finder] ERROR");
        $finish;
    end

endmodule
